// ===== src/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_SLOTS = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0_7   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_8_15  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_16_23 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_24_31 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_BIAS = 3'd6;

    localparam logic [5:0]  PATTERN_LEN_RESET   = 6'd1;
    localparam logic [31:0] POSITION_BIAS_RESET = 32'h0000_1000;

    typedef struct packed {
        logic [31:0] match_position;
        logic [31:0] match_total;
        logic        summary_record;
    } record_t;

endpackage

// ===== src/mbps_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mbps_out_fifo
// Small result queue: one record written and one read per cycle unless stalled.
// ----------------------------------------------------------------------------
module mbps_out_fifo
    import mbps_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output record_t out_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & ~out_stall;
    assign out_rec   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result queue written while full");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("result queue count lost a beat");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("result queue read while empty");

endmodule

// ===== src/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams the bytes of a buffer through a sliding window and reports every
// window start whose cared bytes equal the configured pattern, then a summary
// with the match count at the end of the buffer.
//
// One byte is taken per cycle while in_stall is low and held in the input
// stage until consumed; there the window is compared in parallel against a
// pattern pre-aligned to the active length, and its records pass a two-beat
// result queue whose count register drives out_valid. The queue takes one
// record per cycle, so a final byte of a buffer that also matches holds the
// input stage for its summary. Configuration must be written while the block
// is idle, unenforced; changes reach the compare via the aligned registers.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_buffer,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            match_position,
    output logic [31:0]            match_total,
    output logic                   summary_record
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    // configuration registers
    logic [8*PATTERN_SLOTS-1:0] pattern_reg;
    logic [PATTERN_SLOTS-1:0]   care_reg;
    logic [5:0]                 length_reg;
    logic [31:0]                bias_reg;

    // pattern aligned to the window
    logic [7:0]                 apat_reg  [MAX_PATTERN_BYTES];
    logic [7:0]                 apat_next [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] acare_reg, acare_next;
    logic [LEN_W-1:0]           alen_reg, alen_next;
    logic [31:0]                abias_reg, abias_next;

    // input stage
    logic [7:0]                 window_reg [MAX_PATTERN_BYTES];
    logic [31:0]                seen_reg, seen_next;
    logic                       restart_reg;
    logic                       a_valid_reg, a_valid_next;
    logic                       a_last_reg;
    logic                       phase_reg, phase_next;
    logic [31:0]                matches_reg, matches_next;

    logic                       accept;
    logic                       consume;
    logic                       push;
    logic                       hit;
    logic [MAX_PATTERN_BYTES-1:0] miss;
    record_t                    push_rec;
    record_t                    out_rec;
    logic                       full;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '0;
            length_reg  <= PATTERN_LEN_RESET;
            bias_reg    <= POSITION_BIAS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_PATTERN_0_7:   pattern_reg[63:0]    <= cfg_data;
                CFG_PATTERN_8_15:  pattern_reg[127:64]  <= cfg_data;
                CFG_PATTERN_16_23: pattern_reg[191:128] <= cfg_data;
                CFG_PATTERN_24_31: pattern_reg[255:192] <= cfg_data;
                CFG_CARE_MASK:     care_reg             <= cfg_data[31:0];
                CFG_PATTERN_LEN:   length_reg           <= cfg_data[5:0];
                CFG_POSITION_BIAS: bias_reg             <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // align pattern and mask to the active length
    always_comb
    begin
        logic [5:0] len6;
        logic [5:0] src;
        if (length_reg == '0)
        begin
            len6 = 6'd1;
        end
        else if (length_reg > 6'(MAX_PATTERN_BYTES))
        begin
            len6 = 6'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len6 = length_reg;
        end
        alen_next  = LEN_W'(len6);
        abias_next = bias_reg - 32'(len6);
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            src           = len6 - 6'(j) - 6'd1;
            apat_next[j]  = pattern_reg[8*src[4:0] +: 8];
            acare_next[j] = (6'(j) < len6) & care_reg[src[4:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acare_reg <= '0;
            alen_reg  <= LEN_W'(1);
            abias_reg <= POSITION_BIAS_RESET - 32'd1;
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                apat_reg[j] <= '0;
            end
        end
        else
        begin
            acare_reg <= acare_next;
            alen_reg  <= alen_next;
            abias_reg <= abias_next;
            apat_reg  <= apat_next;
        end
    end

    // compare and record generation
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            miss[j] = acare_reg[j] & (window_reg[j] != apat_reg[j]);
        end
    end

    assign hit = a_valid_reg & ~phase_reg & (seen_reg >= 32'(alen_reg)) & ~(|miss);

    always_comb
    begin
        push         = 1'b0;
        consume      = 1'b0;
        phase_next   = phase_reg;
        matches_next = matches_reg;
        push_rec     = '0;
        if (a_valid_reg && !full)
        begin
            if (hit)
            begin
                push                    = 1'b1;
                push_rec.match_position = seen_reg + abias_reg;
                if (matches_reg != '1)
                begin
                    matches_next = matches_reg + 32'd1;
                end
                phase_next = a_last_reg;
                consume    = ~a_last_reg;
            end
            else if (a_last_reg)
            begin
                push                    = 1'b1;
                push_rec.match_total    = matches_reg;
                push_rec.summary_record = 1'b1;
                matches_next            = '0;
                phase_next              = 1'b0;
                consume                 = 1'b1;
            end
            else
            begin
                consume = 1'b1;
            end
        end
    end

    // input stage
    assign in_stall     = a_valid_reg & ~consume;
    assign accept       = in_valid & ~in_stall;
    assign a_valid_next = accept | (a_valid_reg & ~consume);
    assign seen_next    = (restart_reg ? 32'd0 : seen_reg) + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            restart_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            phase_reg   <= 1'b0;
            matches_reg <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            phase_reg   <= phase_next;
            matches_reg <= matches_next;
            if (accept)
            begin
                seen_reg    <= seen_next;
                restart_reg <= end_of_buffer;
                a_last_reg  <= end_of_buffer;
            end
        end
    end

    // advance the window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[0] <= data_byte;
            for (int k = 1; k < MAX_PATTERN_BYTES; k++)
            begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    mbps_out_fifo #(
        .DEPTH (2)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rec   (out_rec)
    );

    assign match_position = out_rec.match_position;
    assign match_total    = out_rec.match_total;
    assign summary_record = out_rec.summary_record;

    a_phase_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (a_valid_reg && a_last_reg))
        else $error("pending summary without a final beat in the input stage");

    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && !full) |-> (push && push_rec.summary_record && consume))
        else $error("summary not issued after a match on the final beat");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_rec.summary_record) |=> (matches_reg == '0))
        else $error("match count not cleared after summary");

    a_restart_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart_reg) |=> (seen_reg == 32'd1))
        else $error("byte count not restarted on a new buffer");

endmodule
